[rtl/gdo_pkg.sv]
`default_nettype none
package gdo_pkg;

  localparam int FUNC_W  = 2;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int ORD_W   = 9;
  localparam int DAYV_W  = 23;
  localparam int DOUT_W  = 6;
  localparam int DOY_W   = 9;
  localparam int ACC_W   = 24;
  localparam int QUO_W   = 10;
  localparam int RES_W   = 5;
  localparam int RECIP_W = 15;
  localparam int RECIP_SH = 19;
  localparam int QDEPTH  = 2;

  localparam logic [FUNC_W-1:0] FUNC_DOY  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DATE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DIFF = 2'd2;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // ceil(2^19 / 25), exact for all 14-bit years
  localparam logic [RECIP_W-1:0] RECIP25   = 15'd20972;
  localparam logic [RES_W-1:0]   R25_LAST  = 5'd24;
  localparam logic [DOY_W-1:0]   DAYS_YEAR = 9'd365;
  localparam logic [DOY_W-1:0]   DAYS_LEAP = 9'd366;
  localparam logic [ACC_W-1:0]   DAYV_MAX  = 24'd4194303;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [MONTH_W-1:0] month_lo;
    logic [DAY_W-1:0]   day_lo;
    logic [YEAR_W-1:0]  year_lo;
    logic [QUO_W-1:0]   quo_lo;
    logic [MONTH_W-1:0] month_hi;
    logic [DAY_W-1:0]   day_hi;
    logic [YEAR_W-1:0]  year_hi;
    logic [QUO_W-1:0]   quo_hi;
    logic [ORD_W-1:0]   ordinal;
  } gdo_entry_t;

  function automatic logic [QUO_W-1:0] quot25(input logic [YEAR_W-1:0] year);
    logic [YEAR_W+RECIP_W-1:0] prod;
    prod = YEAR_W'(0) + year * RECIP25;
    return prod[RECIP_SH+QUO_W-1:RECIP_SH];
  endfunction

  function automatic logic [RES_W-1:0] res25(input logic [YEAR_W-1:0] year,
                                             input logic [QUO_W-1:0]  quo);
    logic [YEAR_W-1:0] q25;
    logic [YEAR_W-1:0] diff;
    q25  = (YEAR_W'(quo) << 4) + (YEAR_W'(quo) << 3) + YEAR_W'(quo);
    diff = year - q25;
    return diff[RES_W-1:0];
  endfunction

  // div by 100 is div by 4 and 25, div by 400 is div by 16 and 25
  function automatic logic is_leap(input logic [YEAR_W-1:0] year,
                                   input logic [RES_W-1:0]  r25);
    return (year[1:0] == 2'd0) && ((r25 != '0) || (year[3:0] == 4'd0));
  endfunction

  function automatic logic [DOY_W-1:0] month_base(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] b;
    case (month)
      4'd2:    b = 9'd31;
      4'd3:    b = 9'd59;
      4'd4:    b = 9'd90;
      4'd5:    b = 9'd120;
      4'd6:    b = 9'd151;
      4'd7:    b = 9'd181;
      4'd8:    b = 9'd212;
      4'd9:    b = 9'd243;
      4'd10:   b = 9'd273;
      4'd11:   b = 9'd304;
      4'd12:   b = 9'd334;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  function automatic logic [DOY_W-1:0] doy(input logic [MONTH_W-1:0] month,
                                           input logic [DAY_W-1:0]   day,
                                           input logic               lp);
    logic [DOY_W-1:0] d;
    d = DOY_W'(day);
    if (month >= MONTH_FEB && month <= MONTH_DEC) begin
      d = d + month_base(month);
      if (month >= MONTH_MAR && lp) begin
        d = d + DOY_W'(1);
      end
    end
    return d;
  endfunction

endpackage
`default_nettype wire

[rtl/gdo_front.sv]
`default_nettype none
module gdo_front import gdo_pkg::*; (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [MONTH_W-1:0] in_month_a,
  input  wire logic [DAY_W-1:0]   in_day_a,
  input  wire logic [YEAR_W-1:0]  in_year_a,
  input  wire logic [MONTH_W-1:0] in_month_b,
  input  wire logic [DAY_W-1:0]   in_day_b,
  input  wire logic [YEAR_W-1:0]  in_year_b,
  input  wire logic [ORD_W-1:0]   in_ordinal,
  input  wire logic               q_full,
  output logic                    q_push,
  output gdo_entry_t              q_entry
);

  logic             flip;
  logic [QUO_W-1:0] quo_a;
  logic [QUO_W-1:0] quo_b;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign quo_a = quot25(in_year_a);
  assign quo_b = quot25(in_year_b);

  // date ordering only matters for the difference word
  assign flip = (in_func == FUNC_DIFF) &&
                ((in_year_a > in_year_b) ||
                 (in_year_a == in_year_b && in_month_a > in_month_b) ||
                 (in_year_a == in_year_b && in_month_a == in_month_b &&
                  in_day_a > in_day_b));

  always_comb begin
    q_entry.func    = in_func;
    q_entry.ordinal = in_ordinal;
    if (flip) begin
      q_entry.month_lo = in_month_b;
      q_entry.day_lo   = in_day_b;
      q_entry.year_lo  = in_year_b;
      q_entry.quo_lo   = quo_b;
      q_entry.month_hi = in_month_a;
      q_entry.day_hi   = in_day_a;
      q_entry.year_hi  = in_year_a;
      q_entry.quo_hi   = quo_a;
    end else begin
      q_entry.month_lo = in_month_a;
      q_entry.day_lo   = in_day_a;
      q_entry.year_lo  = in_year_a;
      q_entry.quo_lo   = quo_a;
      q_entry.month_hi = in_month_b;
      q_entry.day_hi   = in_day_b;
      q_entry.year_hi  = in_year_b;
      q_entry.quo_hi   = quo_b;
    end
  end

endmodule
`default_nettype wire

[rtl/gdo_queue.sv]
`default_nettype none
module gdo_queue import gdo_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire gdo_entry_t push_data,
  output logic            full,
  input  wire logic       pop,
  output logic            pop_valid,
  output gdo_entry_t      pop_data
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  gdo_entry_t       mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/gdo_back.sv]
`default_nettype none
module gdo_back import gdo_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire gdo_entry_t          q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [DAYV_W-1:0]        out_day_value,
  output logic [MONTH_W-1:0]       out_month_out,
  output logic [DOUT_W-1:0]        out_day_out,
  output logic [YEAR_W-1:0]        out_year_out
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RES  = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_YEAR = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         state_r;
  gdo_entry_t         ent_r;
  logic [RES_W-1:0]   r_lo_r;
  logic [RES_W-1:0]   r_hi_r;
  logic [YEAR_W-1:0]  y_r;
  logic [RES_W-1:0]   r_r;
  logic [ACC_W-1:0]   acc_r;
  logic               out_valid_r;
  logic [DAYV_W-1:0]  day_value_r;
  logic [MONTH_W-1:0] month_out_r;
  logic [DOUT_W-1:0]  day_out_r;
  logic [YEAR_W-1:0]  year_out_r;

  logic               leap_lo;
  logic               leap_hi;
  logic [DOY_W-1:0]   doy_lo;
  logic [DOY_W-1:0]   doy_hi;
  logic [ACC_W-1:0]   diff_init;
  logic [DOY_W-1:0]   year_days;
  logic [MONTH_W-1:0] srch_month;
  logic [DOY_W-1:0]   srch_start;
  logic [ORD_W:0]     srch_day;
  logic               out_free;
  logic [DAYV_W-1:0]  dv_nxt;
  logic [MONTH_W-1:0] mo_nxt;
  logic [DOUT_W-1:0]  do_nxt;
  logic [YEAR_W-1:0]  yo_nxt;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_free = !out_valid_r || !out_stall;

  assign leap_lo   = is_leap(ent_r.year_lo, r_lo_r);
  assign leap_hi   = is_leap(ent_r.year_hi, r_hi_r);
  assign doy_lo    = doy(ent_r.month_lo, ent_r.day_lo, leap_lo);
  assign doy_hi    = doy(ent_r.month_hi, ent_r.day_hi, leap_hi);
  assign diff_init = ACC_W'(doy_hi) - ACC_W'(doy_lo);
  assign year_days = is_leap(y_r, r_r) ? DAYS_LEAP : DAYS_YEAR;

  // month search against month starts
  always_comb begin
    logic found;
    found      = 1'b0;
    srch_month = MONTH_DEC;
    for (int k = 1; k < 12; k++) begin
      if (!found && ent_r.ordinal < doy(MONTH_W'(k + 1), DAY_W'(1), leap_lo)) begin
        srch_month = MONTH_W'(k);
        found      = 1'b1;
      end
    end
    srch_start = doy(srch_month, DAY_W'(1), leap_lo);
    srch_day   = (ORD_W+1)'(ent_r.ordinal) - (ORD_W+1)'(srch_start) + (ORD_W+1)'(1);
  end

  always_comb begin
    dv_nxt = '0;
    mo_nxt = '0;
    do_nxt = '0;
    yo_nxt = '0;
    case (ent_r.func)
      FUNC_DOY: begin
        dv_nxt = DAYV_W'(doy_lo);
      end
      FUNC_DATE: begin
        mo_nxt = srch_month;
        do_nxt = srch_day[DOUT_W-1:0];
        yo_nxt = ent_r.year_lo;
      end
      FUNC_DIFF: begin
        if (!acc_r[ACC_W-1] && acc_r > DAYV_MAX) begin
          dv_nxt = DAYV_MAX[DAYV_W-1:0];
        end else begin
          dv_nxt = acc_r[DAYV_W-1:0];
        end
      end
      default: begin
        dv_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_data;
    end
    if (state_r == ST_RES) begin
      r_lo_r <= res25(ent_r.year_lo, ent_r.quo_lo);
      r_hi_r <= res25(ent_r.year_hi, ent_r.quo_hi);
    end
    if (state_r == ST_CALC) begin
      acc_r <= diff_init;
      y_r   <= ent_r.year_lo;
      r_r   <= r_lo_r;
    end else if (state_r == ST_YEAR && y_r != ent_r.year_hi) begin
      acc_r <= acc_r + ACC_W'(year_days);
      y_r   <= y_r + YEAR_W'(1);
      r_r   <= (r_r == R25_LAST) ? '0 : r_r + RES_W'(1);
    end
    if (state_r == ST_DONE && out_free) begin
      day_value_r <= dv_nxt;
      month_out_r <= mo_nxt;
      day_out_r   <= do_nxt;
      year_out_r  <= yo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            state_r <= ST_RES;
          end
        end
        ST_RES: begin
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          state_r <= (ent_r.func == FUNC_DIFF) ? ST_YEAR : ST_DONE;
        end
        ST_YEAR: begin
          if (y_r == ent_r.year_hi) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_day_value = day_value_r;
  assign out_month_out = month_out_r;
  assign out_day_out   = day_out_r;
  assign out_year_out  = year_out_r;

endmodule
`default_nettype wire

[rtl/gregorian_date_ordinal_unit.sv]
// channel  handshake           word
// -------  ------------------  -----------------------------------------------
// in       in_valid/in_stall   func, month/day/year a and b, ordinal
// out      out_valid/out_stall day_value, month_out, day_out, year_out
//
// day of year and date words go from queue head through the res, calc and done states
// a difference word also runs the year state, where the accumulator adds one year a cycle
// rst_n is synchronous and clears the queue, sequencer and out_valid
// a 2-word queue lets in_ accept while a word is worked; in_stall rises when it is full
// a result waits in the output register under out_stall and blocks the next result only
`default_nettype none
module gregorian_date_ordinal_unit import gdo_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [MONTH_W-1:0] in_month_a,
  input  wire logic [DAY_W-1:0]   in_day_a,
  input  wire logic [YEAR_W-1:0]  in_year_a,
  input  wire logic [MONTH_W-1:0] in_month_b,
  input  wire logic [DAY_W-1:0]   in_day_b,
  input  wire logic [YEAR_W-1:0]  in_year_b,
  input  wire logic [ORD_W-1:0]   in_ordinal,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [DAYV_W-1:0]       out_day_value,
  output logic [MONTH_W-1:0]      out_month_out,
  output logic [DOUT_W-1:0]       out_day_out,
  output logic [YEAR_W-1:0]       out_year_out
);

  logic       q_full;
  logic       q_push;
  gdo_entry_t q_entry;
  logic       q_pop;
  logic       q_valid;
  gdo_entry_t q_head;

  gdo_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_month_a (in_month_a),
    .in_day_a   (in_day_a),
    .in_year_a  (in_year_a),
    .in_month_b (in_month_b),
    .in_day_b   (in_day_b),
    .in_year_b  (in_year_b),
    .in_ordinal (in_ordinal),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  gdo_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_head)
  );

  gdo_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_day_value (out_day_value),
    .out_month_out (out_month_out),
    .out_day_out   (out_day_out),
    .out_year_out  (out_year_out)
  );

endmodule
`default_nettype wire

[rtl/gdo_checker.sv]
`default_nettype none
module gdo_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [22:0] out_day_value,
  input wire logic [3:0]  out_month_out,
  input wire logic [5:0]  out_day_out,
  input wire logic [13:0] out_year_out
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_day_value) &&
    $stable(out_month_out) && $stable(out_day_out) && $stable(out_year_out))
    else $error("stalled result word changed");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_out <= 4'd12)
    else $error("month out of range");

  a_date_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_month_out != 4'd0 |-> out_day_value == 23'd0)
    else $error("date word carries a day count");

  a_count_no_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_month_out == 4'd0 |-> out_day_out == 6'd0 && out_year_out == 14'd0)
    else $error("count word carries date fields");

endmodule

bind gregorian_date_ordinal_unit gdo_checker u_gdo_checker (.*);
`default_nettype wire
